// File: rtl/core/double_ended_queue_top_defines.svh
// assertion macros for the double-ended queue
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define DEQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("deque assertion failed");
// condition must never be seen outside reset
`define DEQ_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("deque forbidden condition seen");
`else
`define DEQ_ASSERT(label, clk, rst_n, prop)
`define DEQ_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: rtl/core/deq_pkg.sv
// shared types and constants of the double-ended queue
package deq_pkg;

	localparam int DEPTH_DEF   = 1024;
	localparam int FUNC_W      = 3;
	localparam int VALUE_W     = 32;
	localparam int COUNT_OUT_W = 11;

	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic exec;
		logic load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// File: rtl/core/deq_ctrl.sv
// sequencing state machine of the double-ended queue
module deq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  deq_pkg::sts_t sts,
	output deq_pkg::cmd_t cmd
);
	import deq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_LOAD;
			end
			ST_LOAD: begin
				// wait for the output word slot to free up
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/deq_datapath.sv
// ring store, front index, count and output register of the double-ended queue
module deq_datapath #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  deq_pkg::cmd_t                          cmd,
	output deq_pkg::sts_t                          sts,
	input  logic        [deq_pkg::FUNC_W-1:0]      func,
	input  logic signed [deq_pkg::VALUE_W-1:0]     push_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [deq_pkg::VALUE_W-1:0]     read_value,
	output logic                                   was_empty,
	output logic                                   overflow,
	output logic        [deq_pkg::COUNT_OUT_W-1:0] element_count,
	output logic                                   is_empty
);
	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

	logic signed [VALUE_W-1:0] mem [DEPTH];

	op_t                       op_q;
	logic signed [VALUE_W-1:0] push_value_q;
	logic [AW-1:0]             front_q, front_d;
	logic [CW-1:0]             count_q, count_d;
	logic signed [VALUE_W-1:0] rd_data_q;
	logic                      use_rd_q, use_rd_d;
	logic                      empty_hit_q, empty_hit_d;
	logic                      ovf_q, ovf_d;
	logic                      out_valid_q;

	logic                      mem_we, mem_re;
	logic [AW-1:0]             mem_addr;
	logic                      full, empty;
	logic [AW-1:0]             front_dec, front_inc, back_pos;
	logic [CW-1:0]             back_off;
	logic [SW-1:0]             back_sum;

	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + AW'(1);
	// push back lands at front + count, pop and peek back read at front + count - 1
	assign back_off  = (op_q == OP_PUSH_BACK) ? count_q : count_q - CW'(1);
	assign back_sum  = SW'(front_q) + SW'(back_off);
	assign back_pos  = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);

	always_comb begin
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_addr    = front_q;
		front_d     = front_q;
		count_d     = count_q;
		use_rd_d    = 1'b0;
		empty_hit_d = 1'b0;
		ovf_d       = 1'b0;
		if (cmd.exec) begin
			case (op_q)
				OP_PUSH_FRONT: begin
					if (full) begin
						ovf_d = 1'b1;
					end else begin
						mem_we   = 1'b1;
						mem_addr = front_dec;
						front_d  = front_dec;
						count_d  = count_q + CW'(1);
					end
				end
				OP_PUSH_BACK: begin
					if (full) begin
						ovf_d = 1'b1;
					end else begin
						mem_we   = 1'b1;
						mem_addr = back_pos;
						count_d  = count_q + CW'(1);
					end
				end
				OP_POP_FRONT, OP_PEEK_FRONT: begin
					if (empty) begin
						empty_hit_d = 1'b1;
					end else begin
						mem_re   = 1'b1;
						use_rd_d = 1'b1;
						mem_addr = front_q;
						if (op_q == OP_POP_FRONT) begin
							front_d = front_inc;
							count_d = count_q - CW'(1);
						end
					end
				end
				OP_POP_BACK, OP_PEEK_BACK: begin
					if (empty) begin
						empty_hit_d = 1'b1;
					end else begin
						mem_re   = 1'b1;
						use_rd_d = 1'b1;
						mem_addr = back_pos;
						if (op_q == OP_POP_BACK) begin
							count_d = count_q - CW'(1);
						end
					end
				end
				default: begin
					// unused codes leave the state alone
				end
			endcase
		end
	end

	// ring store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= push_value_q;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q         <= op_t'(func);
			push_value_q <= push_value;
		end
		if (cmd.exec) begin
			use_rd_q    <= use_rd_d;
			empty_hit_q <= empty_hit_d;
			ovf_q       <= ovf_d;
		end
		if (cmd.load) begin
			read_value    <= empty_hit_q ? -32'sd1 : (use_rd_q ? rd_data_q : '0);
			was_empty     <= empty_hit_q;
			overflow      <= ovf_q;
			element_count <= COUNT_OUT_W'(count_q);
			is_empty      <= empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			front_q <= front_d;
			count_q <= count_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

// File: rtl/core/double_ended_queue_top.sv
// double-ended queue of signed 32-bit words over a ring store
// a word accepted in the idle state passes the execute and load states before out_valid
// is set; a new word is taken only after the last one loads its result (accept, store access,
// result load), as the single-port ring store is used through its registered read
// a waiting result does not block the next accept; only the load step waits
// reset: arst_n clears front index, count, sequencer and output valid; store is not cleared
`include "double_ended_queue_top_defines.svh"

module double_ended_queue_top #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic        [deq_pkg::FUNC_W-1:0]      func,
	input  logic signed [deq_pkg::VALUE_W-1:0]     push_value,
	// output channel
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [deq_pkg::VALUE_W-1:0]     read_value,
	output logic                                   was_empty,
	output logic                                   overflow,
	output logic        [deq_pkg::COUNT_OUT_W-1:0] element_count,
	output logic                                   is_empty
);
	import deq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: accept, execute, load result
	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// ring store with front index and count, plus the output word register
	deq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.push_value    (push_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_value    (read_value),
		.was_empty     (was_empty),
		.overflow      (overflow),
		.element_count (element_count),
		.is_empty      (is_empty)
	);

	// a dropped push means a full store, so the result cannot be empty
	`DEQ_ASSERT(a_ovf_full, clk, arst_n, out_valid && overflow |-> read_value == 0 && !is_empty)
	// an empty hit leaves the queue empty and returns all ones
	`DEQ_ASSERT(a_empty_hit, clk, arst_n, out_valid && was_empty |-> read_value == -1 && is_empty)
	// one word in flight through the sequencer at a time
	`DEQ_ASSERT(a_one_at_a_time, clk, arst_n, in_valid && in_ready |=> !in_ready)
	`DEQ_ASSERT_NEVER(a_flags_excl, clk, arst_n, out_valid && overflow && was_empty)

endmodule

// File: sim/tb.sv
// self-checking testbench for the double-ended queue: directed edge cases, fill and drain, random traffic
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	// codes with no operation behind them
	localparam logic [FUNC_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] OP_SPARE_7 = 3'd7;

	// word values of interest
	localparam logic [VALUE_W-1:0] EMPTY_WORD = '1;
	localparam logic [VALUE_W-1:0] MAX_WORD   = 32'h7fff_ffff;
	localparam logic [VALUE_W-1:0] MIN_WORD   = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] ZERO_WORD  = '0;

	localparam int SETTLE_CYCLES = 10;
	localparam int MAX_REPORTS   = 10;

	// one result word as the block should present it
	typedef struct packed {
		logic [VALUE_W-1:0]     value;
		logic                   empty_hit;
		logic                   dropped;
		logic [COUNT_OUT_W-1:0] count;
		logic                   now_empty;
	} deq_result_t;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   in_valid   = 1'b0;
	logic                   in_ready;
	logic [FUNC_W-1:0]      func       = '0;
	logic [VALUE_W-1:0]     push_value = '0;
	logic                   out_valid;
	logic                   out_ready  = 1'b0;
	logic [VALUE_W-1:0]     read_value;
	logic                   was_empty;
	logic                   overflow;
	logic [COUNT_OUT_W-1:0] element_count;
	logic                   is_empty;

	// shadow copy of the ring, front index and count
	logic [VALUE_W-1:0] shadow_store [DEPTH];
	int unsigned        shadow_front = 0;
	int unsigned        shadow_count = 0;
	deq_result_t        pending_results [$];

	// idle percentages, changed between phases
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// run statistics
	int n_sent        = 0;
	int n_checked     = 0;
	int n_mismatch    = 0;
	int n_dropped     = 0;
	int n_empty_reads = 0;
	int unsigned peak_count = 0;

	double_ended_queue_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_value   (read_value),
		.was_empty    (was_empty),
		.overflow     (overflow),
		.element_count(element_count),
		.is_empty     (is_empty)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one accepted word to the shadow deque and return the result it must produce
	function automatic deq_result_t apply_word(input logic [FUNC_W-1:0] op,
		input logic [VALUE_W-1:0] word);
		deq_result_t r;
		r = '0;
		case (op)
		OP_PUSH_FRONT, OP_PUSH_BACK: begin
			// full store drops the word and leaves the state alone
			if (shadow_count >= DEPTH) begin
				r.dropped = 1'b1;
				n_dropped++;
			end else if (op == OP_PUSH_FRONT) begin
				shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
				shadow_store[shadow_front] = word;
				shadow_count++;
			end else begin
				shadow_store[(shadow_front + shadow_count) % DEPTH] = word;
				shadow_count++;
			end
		end
		OP_POP_FRONT, OP_PEEK_FRONT, OP_POP_BACK, OP_PEEK_BACK: begin
			// reading an empty queue returns all ones and flags it
			if (shadow_count == 0) begin
				r.value     = EMPTY_WORD;
				r.empty_hit = 1'b1;
				n_empty_reads++;
			end else if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) begin
				r.value = shadow_store[shadow_front];
				if (op == OP_POP_FRONT) begin
					shadow_front = (shadow_front + 1) % DEPTH;
					shadow_count--;
				end
			end else begin
				r.value = shadow_store[(shadow_front + shadow_count - 1) % DEPTH];
				if (op == OP_POP_BACK) begin
					shadow_count--;
				end
			end
		end
		default: begin
			// spare codes only report the unchanged state
		end
		endcase
		if (shadow_count > peak_count) begin
			peak_count = shadow_count;
		end
		r.count     = shadow_count[COUNT_OUT_W-1:0];
		r.now_empty = (shadow_count == 0);
		return r;
	endfunction

	// weighted choice of operation; the remainder goes to peeks and spare codes
	function automatic logic [FUNC_W-1:0] pick_op(input int push_pct, input int pop_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < push_pct) begin
			return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		end
		if (roll < push_pct + pop_pct) begin
			return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
		end
		if (roll < 96) begin
			return $urandom_range(1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
		end
		return $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
	endfunction

	// mostly full-range random words, now and then an extreme
	function automatic logic [VALUE_W-1:0] rand_word();
		case ($urandom_range(15))
		0:       return MAX_WORD;
		1:       return MIN_WORD;
		2:       return EMPTY_WORD;
		3:       return ZERO_WORD;
		default: return $urandom();
		endcase
	endfunction

	// drive one word at the falling edge, hold it until accepted, then predict
	task automatic send_word(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		func       <= op;
		push_value <= word;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_results.insert(pending_results.size(), apply_word(op, word));
		n_sent++;
		@(negedge clk);
	endtask

	// every read and spare code against an empty queue
	task automatic test_empty_reads();
		send_word(OP_POP_FRONT, rand_word());
		send_word(OP_POP_BACK, rand_word());
		send_word(OP_PEEK_FRONT, rand_word());
		send_word(OP_PEEK_BACK, rand_word());
		send_word(OP_SPARE_6, MAX_WORD);
		send_word(OP_SPARE_7, MIN_WORD);
	endtask

	// extreme words at both ends, a stored all-ones word, index wrap below zero
	task automatic test_edge_values();
		send_word(OP_PUSH_FRONT, MAX_WORD);
		send_word(OP_PUSH_BACK, MIN_WORD);
		send_word(OP_PUSH_FRONT, EMPTY_WORD);
		send_word(OP_PUSH_BACK, ZERO_WORD);
		// stored all-ones differs from an empty read only in the empty flags and the count
		send_word(OP_PEEK_FRONT, ZERO_WORD);
		send_word(OP_PEEK_BACK, EMPTY_WORD);
		send_word(OP_SPARE_6, EMPTY_WORD);
		send_word(OP_SPARE_7, rand_word());
		send_word(OP_POP_FRONT, MAX_WORD);
		send_word(OP_POP_BACK, MIN_WORD);
		send_word(OP_POP_FRONT, rand_word());
		send_word(OP_POP_BACK, rand_word());
		send_word(OP_POP_BACK, rand_word());
		send_word(OP_PUSH_BACK, rand_word());
		send_word(OP_POP_FRONT, rand_word());
	endtask

	// fill to capacity from both ends, push into the full store, then drain and read the empty queue
	task automatic test_fill_and_drain();
		while (shadow_count < DEPTH) begin
			send_word(pick_op(100, 0), rand_word());
		end
		// pushes at both ends must be dropped while full
		send_word(OP_PUSH_FRONT, rand_word());
		send_word(OP_PUSH_BACK, rand_word());
		send_word(OP_PEEK_FRONT, rand_word());
		send_word(OP_PEEK_BACK, rand_word());
		repeat (8) begin
			send_word(pick_op(96, 0), rand_word());
		end
		while (shadow_count > 0) begin
			send_word(pick_op(0, 100), rand_word());
		end
		test_empty_reads();
	endtask

	// random walk of pushes and pops, slightly weighted toward pushes
	task automatic test_random_traffic(input int n_words);
		repeat (n_words) begin
			send_word(pick_op(45, 40), rand_word());
		end
	endtask

	// receiver back-pressure, changed at the falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// compare every accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		deq_result_t want;
		deq_result_t got;
		if (out_valid === 1'b1 && out_ready) begin
			got = '{read_value, was_empty, overflow, element_count, is_empty};
			if (pending_results.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= MAX_REPORTS) begin
					$display("%0t: unexpected val %0d emp %b ovf %b cnt %0d nowemp %b",
						$time, $signed(got.value), got.empty_hit, got.dropped, got.count,
						got.now_empty);
				end
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				n_checked++;
				if (got !== want) begin
					n_mismatch++;
					if (n_mismatch <= MAX_REPORTS) begin
						$display("%0t: #%0d expected val %0d emp %b ovf %b cnt %0d nowemp %b",
							$time, n_checked, $signed(want.value), want.empty_hit, want.dropped,
							want.count, want.now_empty);
						$display("%0t: #%0d actual   val %0d emp %b ovf %b cnt %0d nowemp %b",
							$time, n_checked, $signed(got.value), got.empty_hit, got.dropped,
							got.count, got.now_empty);
					end
				end
			end
		end
	end

	// test sequence
	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// phase one: light sender gaps, heavy receiver stalls
		send_idle_pct = 10;
		recv_idle_pct = 64;
		test_empty_reads();
		test_edge_values();
		test_random_traffic(40);

		// phase two: the other way round, across a full fill and drain
		send_idle_pct = 64;
		recv_idle_pct = 10;
		test_fill_and_drain();

		// phase three: back to back
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(40);
		test_edge_values();

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// catch any stray result after the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d words in, %0d results checked, %0d mismatches",
			n_sent, n_checked, n_mismatch);
		$display("queue peaked at %0d words, %0d dropped pushes, %0d empty reads",
			peak_count, n_dropped, n_empty_reads);
		if (n_mismatch == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
